// ===== rtl/ute_pkg.sv =====
// shared types, constants and helpers of the udp tracker exchange engine
package ute_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned LenW     = 5;
  localparam int unsigned CdW      = 16;

  localparam logic [CfgIdxW-1:0] CFG_TX_KEY       = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_FAST_TIMEOUT = 1'b1;

  localparam logic [CdW-1:0] TO_ATT0_MS   = CdW'(15 * 1000);
  localparam logic [CdW-1:0] TO_ATT1_MS   = CdW'(30 * 1000);
  localparam logic [CdW-1:0] TO_ATT2_MS   = CdW'(60 * 1000);
  localparam logic [CdW-1:0] FAST_BASE_MS = CdW'(200);
  localparam logic [CdW-1:0] FAST_STEP_MS = CdW'(100);

  localparam logic [LenW-1:0] LEN_MAX  = LenW'(20);
  localparam logic [LenW-1:0] LEN_HDR  = LenW'(8);
  localparam logic [LenW-1:0] LEN_CONN = LenW'(16);
  localparam logic [LenW-1:0] LEN_ANN  = LenW'(20);
  localparam logic [LenW-1:0] POS_TXID = LenW'(4);

  localparam logic [31:0] ACT_CONNECT  = 32'd0;
  localparam logic [31:0] ACT_ANNOUNCE = 32'd1;
  localparam logic [31:0] ACT_ERROR    = 32'd3;

  localparam logic [1:0] MAX_ATTEMPT = 2'd2;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_CONNECT  = 3'd1,
    EV_ANNOUNCE = 3'd2,
    EV_SUCCESS  = 3'd3,
    EV_TIMEOUT  = 3'd4,
    EV_TRKERR   = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_CONN = 3'b010,
    PH_ANN  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] tx_id;
    logic [63:0] conn_id_out;
    logic [31:0] interval_secs;
    logic        busy_res;
  } result_t;

  typedef struct packed {
    logic            done;
    logic [LenW-1:0] len;
    logic [31:0]     action;
    logic [31:0]     txid;
    logic [63:0]     body;
  } dgram_t;

  function automatic logic [CdW-1:0] timeout_ms(input logic fast, input logic [1:0] att);
    logic [CdW-1:0] res;
    if (fast) begin
      res = FAST_BASE_MS + CdW'(att) * FAST_STEP_MS;
    end else begin
      case (att)
        2'd0:    res = TO_ATT0_MS;
        2'd1:    res = TO_ATT1_MS;
        default: res = TO_ATT2_MS;
      endcase
    end
    return res;
  endfunction

endpackage

// ===== rtl/ute_in_if.sv =====
// input item channel of the udp tracker exchange engine
interface ute_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output func, output data_byte, output last_byte, input ready);
  modport sink (input valid, input func, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/ute_res_if.sv =====
// result item channel of the udp tracker exchange engine
interface ute_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] tx_id;
  logic [63:0] conn_id_out;
  logic [31:0] interval_secs;
  logic        busy_res;

  modport source (output valid, output event_res, output tx_id, output conn_id_out,
                  output interval_secs, output busy_res, input ready);
  modport sink (input valid, input event_res, input tx_id, input conn_id_out,
                input interval_secs, input busy_res, output ready);
endinterface

// ===== rtl/ute_cfg_if.sv =====
// configuration write channel of the udp tracker exchange engine
interface ute_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ute_pkg::CfgIdxW-1:0]  index;
  logic [ute_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ute_rx.sv =====
// datagram byte parser: big-endian header and body shift registers
module ute_rx (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output ute_pkg::dgram_t   dgram_o
);

  logic [ute_pkg::LenW-1:0] pos_q, pos_d;
  logic [31:0]              act_q, act_d;
  logic [31:0]              txid_q, txid_d;
  logic [63:0]              body_q, body_d;

  always_comb begin
    pos_d  = (pos_q < ute_pkg::LEN_MAX) ? pos_q + ute_pkg::LenW'(1) : pos_q;
    act_d  = act_q;
    txid_d = txid_q;
    body_d = body_q;
    if (pos_q < ute_pkg::POS_TXID) begin
      act_d = {act_q[23:0], data_byte_i};
    end else if (pos_q < ute_pkg::LEN_HDR) begin
      txid_d = {txid_q[23:0], data_byte_i};
    end else if (pos_q < ute_pkg::LEN_CONN) begin
      body_d = {body_q[55:0], data_byte_i};
    end
    dgram_o.done   = fire_i & last_byte_i;
    dgram_o.len    = pos_d;
    dgram_o.action = act_d;
    dgram_o.txid   = txid_d;
    dgram_o.body   = body_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      act_q  <= '0;
      txid_q <= '0;
      body_q <= '0;
    end else if (fire_i) begin
      if (last_byte_i) begin
        pos_q  <= '0;
        act_q  <= '0;
        txid_q <= '0;
        body_q <= '0;
      end else begin
        pos_q  <= pos_d;
        act_q  <= act_d;
        txid_q <= txid_d;
        body_q <= body_d;
      end
    end
  end

endmodule

// ===== rtl/ute_ctrl.sv =====
// exchange sequencer: phase, attempts, transaction ids and timeout countdown
module ute_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [1:0]        func_i,
  input  ute_pkg::dgram_t   dgram_i,
  input  logic [31:0]       tx_key_i,
  input  logic              fast_i,
  output ute_pkg::result_t  res_o
);

  ute_pkg::phase_e          phase_q, phase_d;
  logic [1:0]               att_q, att_d;
  logic [31:0]              cnt_q, cnt_d;
  logic [31:0]              txid_q, txid_d;
  logic [63:0]              conn_q, conn_d;
  logic [ute_pkg::CdW-1:0]  cd_q, cd_d;

  logic [31:0]              cnt_inc;
  logic [31:0]              txid_new;
  logic [ute_pkg::CdW-1:0]  cd_dec;
  logic [1:0]               att_inc;
  ute_pkg::event_e          ev;
  logic [31:0]              interval;

  always_comb begin
    cnt_inc  = cnt_q + 32'd1;
    txid_new = cnt_inc ^ tx_key_i;
    cd_dec   = (cd_q != '0) ? cd_q - ute_pkg::CdW'(1) : cd_q;
    att_inc  = att_q + 2'd1;
    phase_d  = phase_q;
    att_d    = att_q;
    cnt_d    = cnt_q;
    txid_d   = txid_q;
    conn_d   = conn_q;
    cd_d     = cd_q;
    ev       = ute_pkg::EV_NONE;
    interval = '0;
    case (func_i)
      ute_pkg::FUNC_START: begin
        if (phase_q == ute_pkg::PH_IDLE) begin
          cnt_d   = cnt_inc;
          txid_d  = txid_new;
          conn_d  = '0;
          att_d   = '0;
          phase_d = ute_pkg::PH_CONN;
          cd_d    = ute_pkg::timeout_ms(fast_i, 2'd0);
          ev      = ute_pkg::EV_CONNECT;
        end
      end
      ute_pkg::FUNC_BYTE: begin
        if (dgram_i.done) begin
          case (phase_q)
            ute_pkg::PH_CONN: begin
              if (dgram_i.len >= ute_pkg::LEN_CONN && dgram_i.action == ute_pkg::ACT_CONNECT
                  && dgram_i.txid == txid_q) begin
                conn_d  = dgram_i.body;
                att_d   = '0;
                cnt_d   = cnt_inc;
                txid_d  = txid_new;
                phase_d = ute_pkg::PH_ANN;
                cd_d    = ute_pkg::timeout_ms(fast_i, 2'd0);
                ev      = ute_pkg::EV_ANNOUNCE;
              end
            end
            ute_pkg::PH_ANN: begin
              if (dgram_i.len >= ute_pkg::LEN_HDR && dgram_i.txid == txid_q) begin
                if (dgram_i.action == ute_pkg::ACT_ERROR) begin
                  phase_d = ute_pkg::PH_IDLE;
                  att_d   = '0;
                  cd_d    = '0;
                  ev      = ute_pkg::EV_TRKERR;
                end else if (dgram_i.action == ute_pkg::ACT_ANNOUNCE
                             && dgram_i.len >= ute_pkg::LEN_ANN) begin
                  interval = dgram_i.body[63:32];
                  phase_d  = ute_pkg::PH_IDLE;
                  att_d    = '0;
                  cd_d     = '0;
                  ev       = ute_pkg::EV_SUCCESS;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ute_pkg::FUNC_TICK: begin
        if (phase_q != ute_pkg::PH_IDLE) begin
          cd_d = cd_dec;
          if (cd_dec == '0) begin
            if (att_q >= ute_pkg::MAX_ATTEMPT) begin
              phase_d = ute_pkg::PH_IDLE;
              att_d   = '0;
              ev      = ute_pkg::EV_TIMEOUT;
            end else begin
              att_d  = att_inc;
              cnt_d  = cnt_inc;
              txid_d = txid_new;
              cd_d   = ute_pkg::timeout_ms(fast_i, att_inc);
              ev     = (phase_q == ute_pkg::PH_CONN) ? ute_pkg::EV_CONNECT
                                                     : ute_pkg::EV_ANNOUNCE;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res_o.event_res     = ev;
    res_o.tx_id         = txid_d;
    res_o.conn_id_out   = conn_d;
    res_o.interval_secs = interval;
    res_o.busy_res      = (phase_d != ute_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ute_pkg::PH_IDLE;
      att_q   <= '0;
      cnt_q   <= '0;
      txid_q  <= '0;
      conn_q  <= '0;
      cd_q    <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      att_q   <= att_d;
      cnt_q   <= cnt_d;
      txid_q  <= txid_d;
      conn_q  <= conn_d;
      cd_q    <= cd_d;
    end
  end

endmodule

// ===== rtl/udp_tracker_exchange_engine_core.sv =====
// top level of the udp tracker exchange engine
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   func, data_byte, last_byte
//   res_o    out  valid/ready   event_res, tx_id, conn_id_out, interval_secs, busy_res
//   cfg_i    in   valid/ready   index, data (0 tx_key, 1 fast_timeout)
//
// one item per cycle sustained while res_o is not stalled; an accepted item passes through
// the input register, one pass of parser and sequencer logic and the result register
// a stalled result holds a full input register, which then takes no further item
// reset clears all exchange state, config and both valid flags
// cfg_i is always ready and takes effect on the next cycle
module udp_tracker_exchange_engine_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ute_in_if.sink     in_i,
  ute_res_if.source  res_o,
  ute_cfg_if.sink    cfg_i
);

  ute_pkg::item_t   item_q;
  logic             in_vld_q;
  ute_pkg::result_t res_q;
  ute_pkg::result_t res_d;
  logic             res_vld_q;
  logic [31:0]      tx_key_q;
  logic             fast_q;
  logic             adv;
  logic             in_fire;
  ute_pkg::dgram_t  dgram;

  assign adv         = in_vld_q & (~res_vld_q | res_o.ready);
  assign in_i.ready  = ~in_vld_q | adv;
  assign in_fire     = in_i.valid & in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_key_q <= '0;
      fast_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ute_pkg::CFG_TX_KEY:       tx_key_q <= cfg_i.data;
        ute_pkg::CFG_FAST_TIMEOUT: fast_q   <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.func      <= in_i.func;
      item_q.data_byte <= in_i.data_byte;
      item_q.last_byte <= in_i.last_byte;
    end
  end

  ute_rx u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (adv & (item_q.func == ute_pkg::FUNC_BYTE)),
    .data_byte_i (item_q.data_byte),
    .last_byte_i (item_q.last_byte),
    .dgram_o     (dgram)
  );

  ute_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .func_i   (item_q.func),
    .dgram_i  (dgram),
    .tx_key_i (tx_key_q),
    .fast_i   (fast_q),
    .res_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = res_vld_q;
  assign res_o.event_res     = res_q.event_res;
  assign res_o.tx_id         = res_q.tx_id;
  assign res_o.conn_id_out   = res_q.conn_id_out;
  assign res_o.interval_secs = res_q.interval_secs;
  assign res_o.busy_res      = res_q.busy_res;

endmodule

// ===== tb/sv/tb_udp_tracker_exchange_engine_core.sv =====
`timescale 1ns / 100ps
// testbench of the udp tracker exchange engine: random exchanges checked by a scoreboard
module tb_udp_tracker_exchange_engine_core;
  import ute_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam logic [1:0]  FUNC_UNUSED    = 2'd3;

  class exchange_scoreboard;
    logic [CfgDataW-1:0] key;
    logic                fast;
    phase_e              ph;
    logic [1:0]          attempt;
    logic [31:0]         tx_cnt;
    logic [31:0]         txid;
    logic [63:0]         conn;
    logic [CdW-1:0]      cd;
    logic [LenW-1:0]     rx_len;
    logic [31:0]         rx_action;
    logic [31:0]         rx_txid;
    logic [63:0]         rx_body;
    result_t             awaited[$];
    int                  errors;

    function new();
      key       = '0;
      fast      = 1'b0;
      ph        = PH_IDLE;
      attempt   = '0;
      tx_cnt    = '0;
      txid      = '0;
      conn      = '0;
      cd        = '0;
      rx_len    = '0;
      rx_action = '0;
      rx_txid   = '0;
      rx_body   = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CFG_TX_KEY) begin
        key = data;
      end else begin
        fast = data[0];
      end
    endfunction

    function logic [CdW-1:0] limit_ms(logic [1:0] att);
      if (fast) begin
        return CdW'(200 + 100 * int'(att));
      end
      case (att)
        2'd0:    return TO_ATT0_MS;
        2'd1:    return TO_ATT1_MS;
        default: return TO_ATT2_MS;
      endcase
    endfunction

    function void bump_txid();
      tx_cnt = tx_cnt + 32'd1;
      txid   = tx_cnt ^ key;
    endfunction

    function void take_item(item_t it);
      result_t     r;
      event_e      ev;
      logic [31:0] ival;
      ev   = EV_NONE;
      ival = '0;
      case (it.func)
        FUNC_START: begin
          if (ph == PH_IDLE) begin
            bump_txid();
            conn    = '0;
            attempt = '0;
            ph      = PH_CONN;
            cd      = limit_ms(2'd0);
            ev      = EV_CONNECT;
          end
        end
        FUNC_BYTE: begin
          if (rx_len < POS_TXID) begin
            rx_action = {rx_action[23:0], it.data_byte};
          end else if (rx_len < LEN_HDR) begin
            rx_txid = {rx_txid[23:0], it.data_byte};
          end else if (rx_len < LEN_CONN) begin
            rx_body = {rx_body[55:0], it.data_byte};
          end
          if (rx_len < LEN_MAX) begin
            rx_len++;
          end
          if (it.last_byte) begin
            if (ph == PH_CONN) begin
              if (rx_len >= LEN_CONN && rx_action == ACT_CONNECT && rx_txid == txid) begin
                conn    = rx_body;
                attempt = '0;
                bump_txid();
                ph      = PH_ANN;
                cd      = limit_ms(2'd0);
                ev      = EV_ANNOUNCE;
              end
            end else if (ph == PH_ANN && rx_len >= LEN_HDR && rx_txid == txid) begin
              if (rx_action == ACT_ERROR) begin
                ph      = PH_IDLE;
                attempt = '0;
                cd      = '0;
                ev      = EV_TRKERR;
              end else if (rx_action == ACT_ANNOUNCE && rx_len >= LEN_ANN) begin
                ival    = rx_body[63:32];
                ph      = PH_IDLE;
                attempt = '0;
                cd      = '0;
                ev      = EV_SUCCESS;
              end
            end
            rx_len    = '0;
            rx_action = '0;
            rx_txid   = '0;
            rx_body   = '0;
          end
        end
        FUNC_TICK: begin
          if (ph != PH_IDLE) begin
            if (cd != '0) begin
              cd--;
            end
            if (cd == '0) begin
              if (attempt == MAX_ATTEMPT) begin
                ph      = PH_IDLE;
                attempt = '0;
                ev      = EV_TIMEOUT;
              end else begin
                attempt++;
                bump_txid();
                cd = limit_ms(attempt);
                ev = (ph == PH_CONN) ? EV_CONNECT : EV_ANNOUNCE;
              end
            end
          end
        end
        default: begin
        end
      endcase
      r.event_res     = ev;
      r.tx_id         = txid;
      r.conn_id_out   = conn;
      r.interval_secs = ival;
      r.busy_res      = (ph != PH_IDLE);
      awaited.push_back(r);
    endfunction

    function void cmp(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h actual %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $error("result item with no item pending");
        errors++;
        return;
      end
      want = awaited.pop_front();
      cmp("event_res", want.event_res, got.event_res);
      cmp("tx_id", want.tx_id, got.tx_id);
      cmp("conn_id_out", want.conn_id_out, got.conn_id_out);
      cmp("interval_secs", want.interval_secs, got.interval_secs);
      cmp("busy_res", want.busy_res, got.busy_res);
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ute_in_if  in_ch ();
  ute_res_if res_ch ();
  ute_cfg_if cfg_ch ();

  udp_tracker_exchange_engine_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  exchange_scoreboard sb;
  int send_gap_pct = 0;
  int stall_pct    = 0;
  int item_cnt     = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      sb.check_result({res_ch.event_res, res_ch.tx_id, res_ch.conn_id_out,
                       res_ch.interval_secs, res_ch.busy_res});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_udp_tracker_exchange_engine_core NOT OK");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] func, input logic [7:0] data, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.func      <= 2'($urandom);
      in_ch.data_byte <= 8'($urandom);
      in_ch.last_byte <= 1'($urandom);
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.data_byte <= data;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_item({func, data, last});
    @(negedge clk);
  endtask

  task automatic send(input logic [1:0] func, input logic [7:0] data, input logic last);
    item_cnt++;
    push_item(func, data, last);
  endtask

  task automatic tick_burst(input int n);
    repeat (n) send(FUNC_TICK, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_dgram(input logic [31:0] action, input logic [31:0] id,
                            input logic [63:0] body, input int len);
    logic [159:0] image;
    image = {action, id, body, 32'($urandom)};
    for (int k = 0; k < len; k++) begin
      send(FUNC_BYTE, (k < 20) ? image[159 - 8 * k -: 8] : 8'($urandom), k == len - 1);
    end
  endtask

  task automatic write_regs(input logic [CfgDataW-1:0] key, input logic fast);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_TX_KEY;
    cfg_ch.data  <= key;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_reg(CFG_TX_KEY, key);
    @(negedge clk);
    cfg_ch.index <= CFG_FAST_TIMEOUT;
    cfg_ch.data  <= CfgDataW'(fast);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_reg(CFG_FAST_TIMEOUT, CfgDataW'(fast));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reply_good();
    if (sb.ph == PH_CONN) begin
      send_dgram(ACT_CONNECT, sb.txid, {$urandom, $urandom}, $urandom_range(16, 22));
    end else if ($urandom_range(99) < 25) begin
      send_dgram(ACT_ERROR, sb.txid, {$urandom, $urandom}, $urandom_range(8, 20));
    end else begin
      send_dgram(ACT_ANNOUNCE, sb.txid, {$urandom, $urandom}, $urandom_range(20, 23));
    end
  endtask

  task automatic reply_bad();
    logic [31:0] act;
    logic [63:0] body;
    act  = (sb.ph == PH_CONN) ? ACT_CONNECT : ACT_ANNOUNCE;
    body = {$urandom, $urandom};
    case ($urandom_range(3))
      0: begin
        send_dgram(act, sb.txid ^ (32'h1 << $urandom_range(31)), body, $urandom_range(16, 22));
      end
      1: begin
        send_dgram($urandom_range(1) ? act : ACT_ERROR, sb.txid, body,
                   $urandom_range(1, (sb.ph == PH_CONN) ? 15 : 7));
      end
      2: begin
        send_dgram(act ^ (32'h4 << $urandom_range(29)), sb.txid, body, $urandom_range(16, 22));
      end
      default: begin
        send_dgram($urandom, $urandom, body, $urandom_range(1, 24));
      end
    endcase
  endtask

  task automatic close_exchange();
    while (sb.ph != PH_IDLE) reply_good();
  endtask

  task automatic give_up();
    send(FUNC_START, 8'($urandom), 1'($urandom));
    while (sb.ph != PH_IDLE) tick_burst(sb.cd);
  endtask

  task automatic run_exchange();
    int steps;
    int pick;
    steps = $urandom_range(2, 8);
    send(FUNC_START, 8'($urandom), 1'($urandom));
    while (steps > 0 && sb.ph != PH_IDLE) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        reply_good();
      end else if (pick < 72) begin
        reply_bad();
      end else if (pick < 82) begin
        tick_burst($urandom_range(1, 20));
      end else if (pick < 87) begin
        send(FUNC_START, 8'($urandom), 1'($urandom));
      end else if (pick < 90) begin
        send(FUNC_UNUSED, 8'($urandom), 1'($urandom));
      end else if (pick < 93) begin
        drain();
      end else if (sb.fast) begin
        tick_burst(sb.cd);
      end
      steps--;
    end
  endtask

  task automatic random_items(input int quota);
    int stop_at;
    int pick;
    stop_at = item_cnt + quota;
    while (item_cnt < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_dgram(32'($urandom_range(3)), sb.txid, {$urandom, $urandom}, $urandom_range(1, 24));
      end else if (pick < 13) begin
        send(FUNC_TICK, 8'($urandom), 1'($urandom));
      end else if (pick < 15) begin
        send(FUNC_UNUSED, 8'($urandom), 1'($urandom));
      end else begin
        run_exchange();
      end
    end
  endtask

  task automatic set_phase(input int gap_pct, input int stall, input logic [CfgDataW-1:0] key,
                           input logic fast);
    close_exchange();
    drain();
    write_regs(key, fast);
    send_gap_pct = gap_pct;
    stall_pct    = stall;
  endtask

  initial begin
    sb               = new();
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_START;
    in_ch.data_byte  = '0;
    in_ch.last_byte  = 1'b0;
    res_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_TX_KEY;
    cfg_ch.data      = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_regs('0, 1'b1);

    send(FUNC_TICK, 8'h00, 1'b0);
    send(FUNC_UNUSED, 8'hFF, 1'b1);
    // datagram while idle
    send(FUNC_BYTE, 8'hFF, 1'b1);
    send(FUNC_START, 8'h00, 1'b0);
    // start while busy
    send(FUNC_START, 8'hFF, 1'b1);
    send(FUNC_TICK, 8'hFF, 1'b1);
    send_dgram(ACT_CONNECT, sb.txid, '0, 3);
    send_dgram(ACT_CONNECT, sb.txid, '1, 16);
    random_items(60);

    set_phase(0, 0, 32'hFFFF_FFFF, 1'b1);
    give_up();
    random_items(30);
    set_phase(66, 0, $urandom, 1'b1);
    random_items(100);
    set_phase(0, 66, $urandom, 1'b1);
    random_items(100);
    set_phase(12, 12, 32'h8000_0001, 1'b1);
    random_items(60);
    set_phase(12, 12, $urandom, 1'b0);
    random_items(60);

    close_exchange();
    drain();
    if (sb.errors == 0) begin
      $display("tb_udp_tracker_exchange_engine_core OK");
    end else begin
      $display("tb_udp_tracker_exchange_engine_core NOT OK");
    end
    $finish;
  end

endmodule
